[hdl/wsd_pkg.sv]
// shared types and constants for the websocket frame deframer
// no dependencies; imported by all deframer modules
package wsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 64;
  localparam int unsigned KeyW  = 32;

  localparam logic [6:0] LenMaxShort = 7'd125;
  localparam logic [6:0] Len16Code   = 7'd126;
  localparam logic [3:0] Ext16Bytes  = 4'd2;
  localparam logic [3:0] Ext64Bytes  = 4'd8;
  localparam logic [2:0] KeyLastIdx  = 3'd3;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } wsd_kind_e;

  typedef enum logic [4:0] {
    ST_FIRST   = 5'b00001,
    ST_SECOND  = 5'b00010,
    ST_EXTLEN  = 5'b00100,
    ST_KEY     = 5'b01000,
    ST_PAYLOAD = 5'b10000
  } wsd_state_e;

  typedef struct packed {
    wsd_kind_e         kind;
    logic              final_flag;
    logic [2:0]        reserved_bits;
    logic [3:0]        opcode;
    logic [LenW-1:0]   payload_length;
    logic [ByteW-1:0]  payload_byte;
    logic              frame_end;
  } wsd_result_t;

endpackage

[hdl/wsd_parser.sv]
// frame header parser and payload unmasking for one registered byte per cycle while advance_i is high
// depends on wsd_pkg
module wsd_parser import wsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output wsd_result_t      res_o
);

  wsd_state_e        state_q, state_d;
  logic [ByteW-1:0]  hdr_q, hdr_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [3:0]        ext_left_q, ext_left_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [2:0]        key_cnt_q, key_cnt_d;
  logic [LenW-1:0]   remain_q, remain_d;
  logic [1:0]        key_pos_q, key_pos_d;
  logic [ByteW-1:0]  key_byte;
  logic              last_byte;

  // key bytes are taken most significant first
  assign key_byte  = key_q[{~key_pos_q, 3'b000} +: ByteW];
  assign last_byte = (remain_q == LenW'(1));

  always_comb begin
    state_d     = state_q;
    hdr_d       = hdr_q;
    len_d       = len_q;
    ext_left_d  = ext_left_q;
    key_d       = key_q;
    key_cnt_d   = key_cnt_q;
    remain_d    = remain_q;
    key_pos_d   = key_pos_q;
    res_valid_o = 1'b0;

    res_o.kind           = KIND_HEADER;
    res_o.final_flag     = hdr_q[7];
    res_o.reserved_bits  = hdr_q[6:4];
    res_o.opcode         = hdr_q[3:0];
    res_o.payload_length = '0;
    res_o.payload_byte   = '0;
    res_o.frame_end      = 1'b0;

    if (advance_i) begin
      case (state_q)
        ST_SECOND: begin
          if (!byte_i[7]) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ERROR;
            state_d     = ST_FIRST;
          end else begin
            key_d     = '0;
            key_cnt_d = '0;
            if (byte_i[6:0] <= LenMaxShort) begin
              len_d   = LenW'(byte_i[6:0]);
              state_d = ST_KEY;
            end else begin
              len_d      = '0;
              ext_left_d = (byte_i[6:0] == Len16Code) ? Ext16Bytes : Ext64Bytes;
              state_d    = ST_EXTLEN;
            end
          end
        end
        ST_EXTLEN: begin
          len_d      = {len_q[LenW-ByteW-1:0], byte_i};
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_q == 4'd1) begin
            state_d = ST_KEY;
          end
        end
        ST_KEY: begin
          key_d     = {key_q[KeyW-ByteW-1:0], byte_i};
          key_cnt_d = key_cnt_q + 3'd1;
          if (key_cnt_q == KeyLastIdx) begin
            key_cnt_d            = '0;
            remain_d             = len_q;
            key_pos_d            = '0;
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_HEADER;
            res_o.payload_length = len_q;
            res_o.frame_end      = (len_q == '0);
            state_d              = (len_q == '0) ? ST_FIRST : ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          key_pos_d          = key_pos_q + 2'd1;
          remain_d           = remain_q - LenW'(1);
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.payload_byte = byte_i ^ key_byte;
          res_o.frame_end    = last_byte;
          if (last_byte) begin
            state_d = ST_FIRST;
          end
        end
        default: begin
          hdr_d   = byte_i;
          state_d = ST_SECOND;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FIRST;
      hdr_q      <= '0;
      len_q      <= '0;
      ext_left_q <= '0;
      key_q      <= '0;
      key_cnt_q  <= '0;
      remain_q   <= '0;
      key_pos_q  <= '0;
    end else begin
      state_q    <= state_d;
      hdr_q      <= hdr_d;
      len_q      <= len_d;
      ext_left_q <= ext_left_d;
      key_q      <= key_d;
      key_cnt_q  <= key_cnt_d;
      remain_q   <= remain_d;
      key_pos_q  <= key_pos_d;
    end
  end

`ifndef SYNTHESIS
  a_unmasked_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && state_q == ST_SECOND && !byte_i[7]) |=> state_q == ST_FIRST)
    else $error("unmasked frame did not restart parsing");

  a_last_byte_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && state_q == ST_PAYLOAD && last_byte) |=> state_q == ST_FIRST)
    else $error("frame did not end after last payload byte");

  a_header_after_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_HEADER) |=>
      (key_cnt_q == 3'd0 && key_pos_q == 2'd0))
    else $error("key counters not cleared after header");
`endif

endmodule

[hdl/wsd_out_reg.sv]
// result register holding one item until the receiver takes it
// depends on wsd_pkg
module wsd_out_reg import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  wsd_result_t res_i,
  output logic        can_take_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output wsd_result_t res_o
);

  logic        valid_q, valid_d;
  wsd_result_t res_q;

  assign can_take_o  = !valid_q || out_ready_i;
  assign valid_d     = push_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> can_take_o)
    else $error("result pushed over a waiting item");
`endif

endmodule

[hdl/websocket_frame_deframer.sv]
// websocket deframer: takes client bytes, emits headers and unmasked payload bytes
// channels use valid/ready; rx byte enters an input register, the parser
// works on it and the result lands in a result register.
// a byte accepted into the input register reaches out_valid_o through the result register.
// throughput: one byte per cycle while the result register can take an item; bytes that
// give no item (first byte, length, key bytes) still pass through the input register.
// each byte gives zero or one item: a header after the fourth key byte,
// one item per payload byte, or an error item when the mask bit is clear.
// reset puts the parser at the first byte of a frame and empties both registers.
// when the receiver stalls the result register holds its item, the input
// register holds the next byte, and in_ready_o drops once both are full.
// the parser advances one byte only when the result register can take an item.
// depends on wsd_pkg, wsd_parser and wsd_out_reg
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic             final_flag_o,
  output logic [2:0]       reserved_bits_o,
  output logic [3:0]       opcode_o,
  output logic [LenW-1:0]  payload_length_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic             frame_end_o
);

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             advance;
  logic             can_take;
  logic             res_valid;
  wsd_result_t      res;
  wsd_result_t      out_res;

  assign advance    = in_vld_q && can_take;
  assign in_ready_o = !in_vld_q || advance;
  assign in_vld_d   = (in_valid_i && in_ready_o) || (in_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign final_flag_o     = out_res.final_flag;
  assign reserved_bits_o  = out_res.reserved_bits;
  assign opcode_o         = out_res.opcode;
  assign payload_length_o = out_res.payload_length;
  assign payload_byte_o   = out_res.payload_byte;
  assign frame_end_o      = out_res.frame_end;

`ifndef SYNTHESIS
  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_byte_q)))
    else $error("stalled input byte lost");
`endif

endmodule

[verif/tb_websocket_frame_deframer.sv]
// testbench for websocket_frame_deframer: feeds masked client frames, unmasked
// frames and truncated long frames, and checks each item against a local parser
// depends on wsd_pkg and the websocket_frame_deframer rtl
module tb_websocket_frame_deframer import wsd_pkg::*; ();

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomBytes = 1150;
  localparam int unsigned HoldoffAt   = 400;
  localparam int unsigned HoldoffLen  = 300;
  localparam logic [6:0]  Len64Code   = 7'd127;

  typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_enc_e;
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       kind_o;
  logic             final_flag_o;
  logic [2:0]       reserved_bits_o;
  logic [3:0]       opcode_o;
  logic [LenW-1:0]  payload_length_o;
  logic [ByteW-1:0] payload_byte_o;
  logic             frame_end_o;

  websocket_frame_deframer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .final_flag_o     (final_flag_o),
    .reserved_bits_o  (reserved_bits_o),
    .opcode_o         (opcode_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .frame_end_o      (frame_end_o)
  );

  always #2 clk_i = ~clk_i;

  logic [ByteW-1:0] pending_bytes[$];
  wsd_result_t      expected_results[$];
  int unsigned      total_bytes = 0;
  int unsigned      bytes_accepted = 0;
  int unsigned      errors = 0;
  int unsigned      cycle_count = 0;

  // parser state mirrored from the byte stream
  wsd_state_e       parse_phase = ST_FIRST;
  logic [7:0]       frame_hdr = '0;
  logic [LenW-1:0]  len_acc = '0;
  logic [3:0]       ext_left = '0;
  logic [KeyW-1:0]  mask_key = '0;
  logic [2:0]       key_cnt = '0;
  logic [LenW-1:0]  bytes_left = '0;
  logic [1:0]       key_idx = '0;

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
  endtask

  task automatic expect_result(input wsd_result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic parse_byte(input logic [7:0] b);
    wsd_result_t r;
    logic [7:0]  kb;
    r = '0;
    r.final_flag    = frame_hdr[7];
    r.reserved_bits = frame_hdr[6:4];
    r.opcode        = frame_hdr[3:0];
    case (parse_phase)
      ST_SECOND: begin
        if (!b[7]) begin
          r.kind = KIND_ERROR;
          expect_result(r);
          parse_phase = ST_FIRST;
        end else begin
          len_acc  = '0;
          mask_key = '0;
          key_cnt  = '0;
          if (b[6:0] <= LenMaxShort) begin
            len_acc     = LenW'(b[6:0]);
            parse_phase = ST_KEY;
          end else begin
            ext_left    = (b[6:0] == Len16Code) ? Ext16Bytes : Ext64Bytes;
            parse_phase = ST_EXTLEN;
          end
        end
      end
      ST_EXTLEN: begin
        len_acc  = {len_acc[LenW-9:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) parse_phase = ST_KEY;
      end
      ST_KEY: begin
        mask_key = {mask_key[KeyW-9:0], b};
        if (key_cnt == KeyLastIdx) begin
          key_cnt          = '0;
          bytes_left       = len_acc;
          key_idx          = '0;
          r.kind           = KIND_HEADER;
          r.payload_length = len_acc;
          r.frame_end      = (len_acc == '0);
          expect_result(r);
          parse_phase = (len_acc == '0) ? ST_FIRST : ST_PAYLOAD;
        end else begin
          key_cnt = key_cnt + 3'd1;
        end
      end
      ST_PAYLOAD: begin
        // key bytes are used most significant first
        kb             = mask_key[8 * (3 - key_idx) +: 8];
        key_idx        = key_idx + 2'd1;
        bytes_left     = bytes_left - LenW'(1);
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b ^ kb;
        r.frame_end    = (bytes_left == '0);
        expect_result(r);
        if (bytes_left == '0) parse_phase = ST_FIRST;
      end
      default: begin
        frame_hdr   = b;
        parse_phase = ST_SECOND;
      end
    endcase
  endtask

  task automatic queue_frame(input logic [7:0] first, input len_enc_e enc,
                             input logic [LenW-1:0] len, input logic [KeyW-1:0] key,
                             input int pay_count);
    queue_byte(first);
    case (enc)
      LEN_EXT16: begin
        queue_byte({1'b1, Len16Code});
        queue_byte(len[15:8]);
        queue_byte(len[7:0]);
      end
      LEN_EXT64: begin
        queue_byte({1'b1, Len64Code});
        for (int i = 7; i >= 0; i--) queue_byte(len[8 * i +: 8]);
      end
      default: queue_byte({1'b1, len[6:0]});
    endcase
    for (int i = 3; i >= 0; i--) queue_byte(key[8 * i +: 8]);
    for (int i = 0; i < pay_count; i++) queue_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_unmasked(input logic [7:0] first, input logic [6:0] len7);
    queue_byte(first);
    queue_byte({1'b0, len7});
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned idle_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_byte(rx_byte_i);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (idle_left != 0 || pending_bytes.size() == 0) begin
          in_valid_i <= 1'b0;
          if (idle_left != 0) idle_left <= idle_left - 1;
        end else begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= pending_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps going
  int unsigned holdoff_left = 0;
  logic        holdoff_done = 1'b0;

  always @(posedge clk_i) begin
    if (!holdoff_done && bytes_accepted >= HoldoffAt) begin
      holdoff_left <= HoldoffLen;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // receiver: checks items and stalls on a changing pattern
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned mode_left = 0;
  logic [1:0]  sparse_cnt = '0;

  always @(posedge clk_i) begin : rx_side
    logic go;
    wsd_result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item, expected none actual kind %0h length %0h byte %0h",
                   $time, kind_o, payload_length_o, payload_byte_o);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind", 64'(exp_r.kind), 64'(kind_o));
          check_field("final_flag", 64'(exp_r.final_flag), 64'(final_flag_o));
          check_field("reserved_bits", 64'(exp_r.reserved_bits), 64'(reserved_bits_o));
          check_field("opcode", 64'(exp_r.opcode), 64'(opcode_o));
          check_field("payload_length", exp_r.payload_length, payload_length_o);
          check_field("payload_byte", 64'(exp_r.payload_byte), 64'(payload_byte_o));
          check_field("frame_end", 64'(exp_r.frame_end), 64'(frame_end_o));
        end
      end
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      sparse_cnt <= sparse_cnt + 2'd1;
      case (rx_mode)
        RX_RANDOM: go = ($urandom_range(0, 1) == 1);
        RX_SPARSE: go = (sparse_cnt == 2'd0);
        RX_MOSTLY: go = ($urandom_range(0, 9) != 0);
        default:   go = 1'b1;
      endcase
      out_ready_i <= go && (holdoff_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned directed_bytes;
    int unsigned pick;
    logic [LenW-1:0] len;

    // zero length with all header bits set, unmasked frame, short and 16-bit lengths
    queue_frame(8'hFF, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
    queue_unmasked(8'h00, 7'h7F);
    queue_frame(8'h81, LEN_SHORT, 64'd1, 32'h0000_0000, 1);
    queue_frame(8'h72, LEN_EXT16, 64'd2, 32'hA5C3_0F96, 2);
    directed_bytes = pending_bytes.size();

    while (pending_bytes.size() < directed_bytes + RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        len = LenW'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                 : $urandom_range(13, 125));
        queue_frame(8'($urandom_range(0, 255)), LEN_SHORT, len, $urandom, int'(len));
      end else if (pick < 70) begin
        len = LenW'(($urandom_range(0, 3) == 0) ? $urandom_range(126, 300)
                                                : $urandom_range(0, 20));
        queue_frame(8'($urandom_range(0, 255)), LEN_EXT16, len, $urandom, int'(len));
      end else if (pick < 85) begin
        len = LenW'($urandom_range(0, 20));
        queue_frame(8'($urandom_range(0, 255)), LEN_EXT64, len, $urandom, int'(len));
      end else begin
        queue_unmasked(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      end
    end

    // maximal 64-bit length, top bit set and never checked; stream stops mid-payload
    queue_frame(8'h8A, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 6);
    total_bytes = pending_bytes.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted != total_bytes || expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
